@@ sv/ssdcf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdcf_pkg
// shared types, constants and the segment glyph lookup for the display
// command framer
// ----------------------------------------------------------------------------
package ssdcf_pkg;

	typedef enum logic [1:0] {
		ACT_DEC = 2'd0,
		ACT_HEX = 2'd1,
		ACT_ON  = 2'd2,
		ACT_OFF = 2'd3
	} action_t;

	localparam int NUM_REGS = 6;
	localparam int NUM_CMDS = 5;

	localparam logic [2:0] REG_SYS_ON    = 3'd0;
	localparam logic [2:0] REG_SYS_EIGHT = 3'd1;
	localparam logic [2:0] REG_DIGIT0    = 3'd2;
	localparam logic [2:0] REG_DIGIT1    = 3'd3;
	localparam logic [2:0] REG_DIGIT2    = 3'd4;
	localparam logic [2:0] REG_DIGIT3    = 3'd5;

	localparam logic [15:0] REG_RESET [NUM_REGS] = '{
		16'd1025, 16'd1025, 16'd5120, 16'd5376, 16'd5632, 16'd5888
	};

	// byte counter value of the final byte of a run
	localparam logic [3:0] LAST_BYTE_IDX = 4'd9;

	localparam logic [7:0] SEG_ALL_ON  = 8'hFF;
	localparam logic [7:0] SEG_ALL_OFF = 8'h00;

	// 2^26 / 1000 rounded up, exact for all 16-bit values
	localparam logic [16:0] RECIP_1000 = 17'd67109;
	// 2^11 / 10 rounded up, exact below 1024
	localparam logic [7:0]  RECIP_10   = 8'd205;
	// 2^12 / 100 rounded up, exact below 1000
	localparam logic [5:0]  RECIP_100  = 6'd41;

	typedef logic [15:0] cmd_word_t;
	typedef cmd_word_t [NUM_CMDS-1:0] cmd_words_t;

	// handoff from the last pipeline stage into the byte serializer
	typedef struct packed {
		logic       valid;
		cmd_words_t words;
	} ser_load_t;

	function automatic logic [7:0] glyph(input logic [3:0] idx);
		logic [7:0] seg;
		case (idx)
			4'h0: seg = 8'h3F;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5B;
			4'h3: seg = 8'h4F;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6D;
			4'h6: seg = 8'h7D;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7F;
			4'h9: seg = 8'h6F;
			4'hA: seg = 8'h77;
			4'hB: seg = 8'h7C;
			4'hC: seg = 8'h39;
			4'hD: seg = 8'h5E;
			4'hE: seg = 8'h79;
			4'hF: seg = 8'h71;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

@@ sv/ssdcf_serializer.sv @@
// ----------------------------------------------------------------------------
// ssdcf_serializer
// holds five command words and sends them as ten framed bus bytes
// ----------------------------------------------------------------------------
module ssdcf_serializer
	import ssdcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ser_load_t  load,
	output logic       load_ready,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // bus_byte
	output logic [1:0] m_axis_tuser,   // start_before, stop_after
	output logic       m_axis_tlast    // last_byte
);

	logic       busy_q;
	logic [3:0] cnt_q;
	cmd_words_t words_q;
	cmd_word_t  cur_word;
	logic       out_fire;
	logic       run_done;

	assign out_fire   = busy_q && m_axis_tready;
	assign run_done   = out_fire && (cnt_q == LAST_BYTE_IDX);
	assign load_ready = !busy_q || run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load_ready) begin
			busy_q <= load.valid;
			cnt_q  <= '0;
		end else if (out_fire) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load.valid) begin
			words_q <= load.words;
		end
	end

	assign cur_word = words_q[cnt_q[3:1]];

	always_comb begin
		m_axis_tvalid = busy_q;
		m_axis_tlast  = (cnt_q == LAST_BYTE_IDX);
		if (!cnt_q[0]) begin
			// address byte: bits 12..8 of the word land in bits 5..1
			m_axis_tdata = {2'b01, cur_word[12:8], 1'b0};
			m_axis_tuser = 2'b01;
		end else begin
			m_axis_tdata = cur_word[7:0];
			m_axis_tuser = 2'b10;
		end
	end

endmodule

@@ sv/seven_segment_display_command_framer.sv @@
// ----------------------------------------------------------------------------
// seven_segment_display_command_framer
// turns one display request into the ten bus bytes for a four-digit
// seven-segment driver on a two-wire bus
// ----------------------------------------------------------------------------
// usage
//  - s_axis: one request per transaction (action, value, four hex glyph
//    indices, brightness); s_axis_tready drops only when the pipeline is full
//  - m_axis: ten bytes per request, system command then digits one to four,
//    each command as an address byte (start_before) and a data byte
//    (stop_after); tlast marks the tenth byte
//  - cfg: register writes (index, data), always ready, only while idle
// path: a request passes pipeline stages 1 to 4 and is then loaded into the
//   serializer; the bytes follow one per cycle while tready stays high
// throughput: the serializer emits one bus byte per cycle while m_axis_tready
//   is high, ten per request; four pipeline stages in front of it let up to
//   four further requests queue while a run is still going out
// reset: arst_n clears every valid bit and loads the register defaults
// stall: a low m_axis_tready holds the current byte; the pipeline fills up
//   and then drops s_axis_tready, nothing is lost or repeated
// ----------------------------------------------------------------------------
module seven_segment_display_command_framer
	import ssdcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[1:0], display_value[17:2], hex_digit_a[21:18], hex_digit_b[25:22],
	// hex_digit_c[29:26], hex_digit_d[33:30], brightness[41:34], zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // bus_byte
	output logic [1:0]  m_axis_tuser,   // start_before, stop_after
	output logic        m_axis_tlast,   // last_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] cfg_q [NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_valid && (cfg_index < 3'(NUM_REGS))) begin
			// out of range indexes are dropped
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// request fields
	action_t     in_action;
	logic [15:0] in_value;
	logic [15:0] in_hex;
	logic [7:0]  in_bright;

	assign in_action = action_t'(s_axis_tdata[1:0]);
	assign in_value  = s_axis_tdata[17:2];
	assign in_hex    = s_axis_tdata[33:18];
	assign in_bright = s_axis_tdata[41:34];

	// pipeline valid bits and backpressure chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ser_ready;

	assign rdy4          = !v_s4 || ser_ready;
	assign rdy3          = !v_s3 || rdy4;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: capture and start the divide by 1000
	action_t     act_s1;
	logic [15:0] val_s1;
	logic [15:0] hex_s1;
	logic [7:0]  br_s1;
	logic [32:0] prod_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			act_s1  <= in_action;
			val_s1  <= in_value;
			hex_s1  <= in_hex;
			br_s1   <= in_bright;
			prod_s1 <= in_value * RECIP_1000;
		end
	end

	// stage 2: thousands quotient and remainder below 1000
	action_t     act_s2;
	logic [15:0] hex_s2;
	logic [7:0]  br_s2;
	logic [6:0]  thou_s2;
	logic [9:0]  rem_s2;
	logic [6:0]  thou_c;
	logic [15:0] rem1_c;

	assign thou_c = prod_s1[32:26];
	assign rem1_c = val_s1 - (16'(thou_c) * 16'd1000);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			act_s2  <= act_s1;
			hex_s2  <= hex_s1;
			br_s2   <= br_s1;
			thou_s2 <= thou_c;
			rem_s2  <= rem1_c[9:0];
		end
	end

	// stage 3: thousands digit (ten-thousands wrap) and hundreds digit
	action_t     act_s3;
	logic [15:0] hex_s3;
	logic [7:0]  br_s3;
	logic [3:0]  dth_s3;
	logic [3:0]  dhu_s3;
	logic [6:0]  rem_s3;
	logic [13:0] thou_mul_c;
	logic [2:0]  thou_div_c;
	logic [6:0]  dth_c;
	logic [15:0] hun_mul_c;
	logic [3:0]  hun_c;
	logic [9:0]  rem2_c;

	assign thou_mul_c = thou_s2 * RECIP_10;
	assign thou_div_c = thou_mul_c[13:11];
	assign dth_c      = thou_s2 - (7'(thou_div_c) * 7'd10);
	assign hun_mul_c  = rem_s2 * RECIP_100;
	assign hun_c      = hun_mul_c[15:12];
	assign rem2_c     = rem_s2 - (10'(hun_c) * 10'd100);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			act_s3 <= act_s2;
			hex_s3 <= hex_s2;
			br_s3  <= br_s2;
			dth_s3 <= dth_c[3:0];
			dhu_s3 <= hun_c;
			rem_s3 <= rem2_c[6:0];
		end
	end

	// stage 4: tens and ones, glyphs, command words
	cmd_words_t  words_s4;
	logic [14:0] ten_mul_c;
	logic [3:0]  ten_c;
	logic [6:0]  one_c;
	logic [7:0]  seg_c [4];
	cmd_word_t   sys_c;
	cmd_words_t  words_c;

	assign ten_mul_c = rem_s3 * RECIP_10;
	assign ten_c     = ten_mul_c[14:11];
	assign one_c     = rem_s3 - (7'(ten_c) * 7'd10);

	always_comb begin
		case (act_s3)
			ACT_DEC: begin
				sys_c    = cfg_q[REG_SYS_ON] | {8'd0, br_s3};
				seg_c[0] = glyph(dth_s3);
				seg_c[1] = glyph(dhu_s3);
				seg_c[2] = glyph(ten_c);
				seg_c[3] = glyph(one_c[3:0]);
			end
			ACT_HEX: begin
				sys_c    = cfg_q[REG_SYS_ON] | {8'd0, br_s3};
				seg_c[0] = glyph(hex_s3[3:0]);
				seg_c[1] = glyph(hex_s3[7:4]);
				seg_c[2] = glyph(hex_s3[11:8]);
				seg_c[3] = glyph(hex_s3[15:12]);
			end
			ACT_ON: begin
				sys_c = cfg_q[REG_SYS_EIGHT];
				for (int i = 0; i < 4; i++) seg_c[i] = SEG_ALL_ON;
			end
			default: begin
				sys_c = cfg_q[REG_SYS_EIGHT];
				for (int i = 0; i < 4; i++) seg_c[i] = SEG_ALL_OFF;
			end
		endcase
		words_c[0] = sys_c;
		words_c[1] = cfg_q[REG_DIGIT0] | {8'd0, seg_c[0]};
		words_c[2] = cfg_q[REG_DIGIT1] | {8'd0, seg_c[1]};
		words_c[3] = cfg_q[REG_DIGIT2] | {8'd0, seg_c[2]};
		words_c[4] = cfg_q[REG_DIGIT3] | {8'd0, seg_c[3]};
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			words_s4 <= words_c;
		end
	end

	// byte serializer
	ser_load_t ser_load;

	assign ser_load.valid = v_s4;
	assign ser_load.words = words_s4;

	ssdcf_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (ser_load),
		.load_ready   (ser_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

@@ sv/ssdcf_checker.sv @@
// ----------------------------------------------------------------------------
// ssdcf_checker
// port level checks on the framed byte stream of the display command framer
// ----------------------------------------------------------------------------
module ssdcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output byte changed");

	// address bytes carry the fixed marker bits and no stop
	a_addr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[7:6] == 2'b01 && !m_axis_tdata[0] && !m_axis_tuser[1]
			&& !m_axis_tlast)
		else $error("malformed address byte");

	// the data byte of a command is ready right after its address byte
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=>
			m_axis_tvalid && m_axis_tuser[1])
		else $error("data byte did not follow address byte");

	// the end of a run is always a data byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 2'b10)
		else $error("last byte is not a data byte");

endmodule

bind seven_segment_display_command_framer ssdcf_checker u_ssdcf_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives display requests into the seven-segment command framer and checks
// every bus byte against an in-bench prediction of the five command words
// ----------------------------------------------------------------------------
module tb_top;
	import ssdcf_pkg::*;

	// nothing accepted on any channel for this long means the block hung
	localparam int QUIET_LIMIT = 1000;
	// bus byte slots after the last expected one, to catch extra output
	localparam int TAIL_CYCLES = 20;

	// config indexes past the register file, writes to them must be dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// segment patterns for glyph indices 0..f
	localparam logic [7:0] SEG_GLYPHS [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
	};

	// field order from msb down matches the s_axis_tdata layout from bit 41 down
	typedef struct packed {
		logic [7:0]  brightness;
		logic [3:0]  hex_digit_d;
		logic [3:0]  hex_digit_c;
		logic [3:0]  hex_digit_b;
		logic [3:0]  hex_digit_a;
		logic [15:0] display_value;
		action_t     action;
	} display_request_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       start_before;
		logic       stop_after;
		logic       last_byte;
	} bus_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// bench copy of the command registers, updated on each in-range write
	logic [15:0] shadow_regs [NUM_REGS];
	// bus bytes predicted for accepted requests, oldest first
	bus_byte_t   pending_bus_bytes [$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int src_idle_pct   = 0;
	int snk_stall_pct  = 0;

	seven_segment_display_command_framer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// one command word goes out as an address byte then a data byte
	function automatic void queue_command(input logic [15:0] word, input logic ends_run);
		bus_byte_t b;
		b.bus_byte     = 8'(((word >> 7) & 16'h003E) | 16'h0040);
		b.start_before = 1'b1;
		b.stop_after   = 1'b0;
		b.last_byte    = 1'b0;
		pending_bus_bytes.push_back(b);
		b.bus_byte     = word[7:0];
		b.start_before = 1'b0;
		b.stop_after   = 1'b1;
		b.last_byte    = ends_run;
		pending_bus_bytes.push_back(b);
	endfunction

	// system command first, then the four digit segment commands
	function automatic void predict_bus_bytes(input display_request_t r);
		logic [15:0] sys_word;
		logic [7:0]  seg [4];
		int          k;
		case (r.action)
			ACT_DEC: begin
				sys_word = shadow_regs[REG_SYS_ON] | {8'h00, r.brightness};
				// ten-thousands digit drops out for values of 10000 and up
				seg[0] = SEG_GLYPHS[(r.display_value / 1000) % 10];
				seg[1] = SEG_GLYPHS[(r.display_value / 100) % 10];
				seg[2] = SEG_GLYPHS[(r.display_value / 10) % 10];
				seg[3] = SEG_GLYPHS[r.display_value % 10];
			end
			ACT_HEX: begin
				sys_word = shadow_regs[REG_SYS_ON] | {8'h00, r.brightness};
				seg[0] = SEG_GLYPHS[r.hex_digit_a];
				seg[1] = SEG_GLYPHS[r.hex_digit_b];
				seg[2] = SEG_GLYPHS[r.hex_digit_c];
				seg[3] = SEG_GLYPHS[r.hex_digit_d];
			end
			default: begin
				// brightness is not used by the all-on and all-off actions
				sys_word = shadow_regs[REG_SYS_EIGHT];
				for (k = 0; k < 4; k++)
					seg[k] = (r.action == ACT_ON) ? SEG_ALL_ON : SEG_ALL_OFF;
			end
		endcase
		queue_command(sys_word, 1'b0);
		// base bits are not masked, whatever is in the register shows up
		for (k = 0; k < 4; k++)
			queue_command(shadow_regs[REG_DIGIT0 + k] | {8'h00, seg[k]}, k == 3);
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : check_bus_bytes
		bus_byte_t want;
		if (arst_n === 1'b1 && m_axis_tvalid && m_axis_tready) begin
			if (pending_bus_bytes.size() == 0) begin
				$error("bus byte %02h with no request outstanding", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = pending_bus_bytes.pop_front();
				if (m_axis_tdata !== want.bus_byte) begin
					$error("bus_byte: expected %02h, got %02h", want.bus_byte, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tuser[0] !== want.start_before) begin
					$error("start_before: expected %0d, got %0d",
						want.start_before, m_axis_tuser[0]);
					mismatch_count++;
				end
				if (m_axis_tuser[1] !== want.stop_after) begin
					$error("stop_after: expected %0d, got %0d",
						want.stop_after, m_axis_tuser[1]);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.last_byte) begin
					$error("last_byte: expected %0d, got %0d", want.last_byte, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("seven_segment_display_command_framer: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// shared stimulus tasks
	// ------------------------------------------------------------------------

	function automatic display_request_t make_request(input action_t act, input int value,
			input int a, input int b, input int c, input int d, input int bright);
		display_request_t r;
		r.action        = act;
		r.display_value = value[15:0];
		r.hex_digit_a   = a[3:0];
		r.hex_digit_b   = b[3:0];
		r.hex_digit_c   = c[3:0];
		r.hex_digit_d   = d[3:0];
		r.brightness    = bright[7:0];
		return r;
	endfunction

	// valid stays high after the transaction, a drain or an idle draw in the next call lowers it
	task automatic send_request(input display_request_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_bus_bytes(r);
	endtask

	// hold the sender off until every predicted bus byte has gone out
	task automatic wait_for_bus_bytes();
		s_axis_tvalid <= 1'b0;
		while (pending_bus_bytes.size() != 0)
			@(posedge clk);
	endtask

	// cfg_valid is left high, the caller lowers it after its last write
	task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NUM_REGS)
			shadow_regs[idx] = data;
	endtask

	task automatic load_registers(input logic [15:0] sys_on, input logic [15:0] sys_eight,
			input logic [15:0] digit0, input logic [15:0] digit1,
			input logic [15:0] digit2, input logic [15:0] digit3);
		write_register(REG_SYS_ON, sys_on);
		write_register(REG_SYS_EIGHT, sys_eight);
		write_register(REG_DIGIT0, digit0);
		write_register(REG_DIGIT1, digit1);
		write_register(REG_DIGIT2, digit2);
		write_register(REG_DIGIT3, digit3);
	endtask

	function automatic logic [15:0] pick_register_value();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// register defaults, field extremes, every action and every glyph
	task automatic test_defaults_and_extremes();
		send_request(make_request(ACT_DEC, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_DEC, 9999, 0, 0, 0, 0, 8'hFF));
		// wrap past four digits
		send_request(make_request(ACT_DEC, 10000, 0, 0, 0, 0, 8'h55));
		send_request(make_request(ACT_DEC, 65535, 15, 15, 15, 15, 8'hAA));
		send_request(make_request(ACT_HEX, 0, 0, 1, 2, 3, 8'h00));
		send_request(make_request(ACT_HEX, 0, 4, 5, 6, 7, 8'hFF));
		send_request(make_request(ACT_HEX, 0, 8, 9, 10, 11, 8'h0F));
		// value field is ignored by the hex action
		send_request(make_request(ACT_HEX, 65535, 12, 13, 14, 15, 8'hF0));
		send_request(make_request(ACT_ON, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_ON, 65535, 15, 15, 15, 15, 8'hFF));
		send_request(make_request(ACT_OFF, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_OFF, 65535, 15, 15, 15, 15, 8'hFF));
	endtask

	// all registers cleared, then all set, with writes past the register file
	task automatic test_register_extremes();
		wait_for_bus_bytes();
		load_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		cfg_valid <= 1'b0;
		send_request(make_request(ACT_DEC, 8888, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_HEX, 0, 15, 0, 15, 0, 8'hFF));
		send_request(make_request(ACT_ON, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_OFF, 0, 0, 0, 0, 0, 8'h00));
		wait_for_bus_bytes();
		load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// these must not land in any register
		write_register(REG_SPARE_LO, 16'h0000);
		write_register(REG_SPARE_HI, 16'h0000);
		cfg_valid <= 1'b0;
		send_request(make_request(ACT_DEC, 1234, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_HEX, 0, 3, 7, 11, 15, 8'h00));
		send_request(make_request(ACT_ON, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_request(ACT_OFF, 0, 0, 0, 0, 0, 8'h00));
	endtask

	// random requests under one register setting and one idle pattern
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_requests);
		display_request_t r;
		int               i;
		wait_for_bus_bytes();
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		load_registers(pick_register_value(), pick_register_value(), pick_register_value(),
			pick_register_value(), pick_register_value(), pick_register_value());
		cfg_valid <= 1'b0;
		for (i = 0; i < n_requests; i++) begin
			r.action        = action_t'($urandom_range(0, 3));
			// keep most values in four-digit range, the rest across the full field
			r.display_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 9999))
				: 16'($urandom_range(0, 16'hFFFF));
			r.hex_digit_a   = 4'($urandom_range(0, 15));
			r.hex_digit_b   = 4'($urandom_range(0, 15));
			r.hex_digit_c   = 4'($urandom_range(0, 15));
			r.hex_digit_d   = 4'($urandom_range(0, 15));
			r.brightness    = 8'($urandom_range(0, 255));
			send_request(r);
			// let the pipeline run empty now and then
			if (i == n_requests / 2 || $urandom_range(0, 24) == 0)
				wait_for_bus_bytes();
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		int i;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		for (i = 0; i < NUM_REGS; i++)
			shadow_regs[i] = REG_RESET[i];
		src_idle_pct  = 10;
		snk_stall_pct = 62;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_extremes();
		test_register_extremes();
		test_random_traffic(10, 62, 64);
		test_random_traffic(62, 10, 64);
		test_random_traffic(0, 0, 64);

		wait_for_bus_bytes();
		// any stray byte after the last run shows up here
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_bus_bytes.size() != 0) begin
			$error("%0d bus bytes never arrived", pending_bus_bytes.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("seven_segment_display_command_framer: match");
		end else begin
			$display("seven_segment_display_command_framer: mismatch");
		end
		$finish;
	end

endmodule
